### design/trimmed_mean_block_filter_macros.svh
// ----------------------------------------------------------------------------
// Trimmed-mean block filter assertion macros
// Short forms for the concurrent checks on the filter ports.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_BLOCK_FILTER_MACROS_SVH
`define TRIMMED_MEAN_BLOCK_FILTER_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define TMBF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds, consequent holds in the next cycle.
`define TMBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check that is live while reset is asserted.
`define TMBF_ASSERT_RESET(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tmbf_pkg.sv
// ----------------------------------------------------------------------------
// tmbf_pkg
// Widths, command/status types and helpers shared by the trimmed-mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmbf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 5;
   localparam int WINDOW_MAX = 16;
   localparam int TRIM_COUNT = 2;
   localparam int LEN_MIN    = 3;
   localparam int LEN_RESET  = 5;

   // longest window the length register can actually express
   localparam int LEN_CAP = (WINDOW_MAX < 2**LEN_W) ? WINDOW_MAX : 2**LEN_W - 1;

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX) + 1;
   localparam int KEPT_W = SUM_W + 1;
   localparam int CNT_W  = $clog2(KEPT_W);

   typedef struct packed {
      logic take;   // request accepted, update accumulators
      logic prep;   // load divider from accumulators
      logic step;   // one quotient bit
      logic load;   // write result register
   } tmbf_cmd_type;

   typedef struct packed {
      logic window_done;   // the request on the port closes the window
      logic div_last;      // final quotient bit this cycle
      logic out_busy;      // result register still held
   } tmbf_status_type;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] eff;
      if (int'(len) < LEN_MIN) begin
         eff = LEN_W'(LEN_MIN);
      end else if (int'(len) > LEN_CAP) begin
         eff = LEN_W'(LEN_CAP);
      end else begin
         eff = len;
      end
      return eff;
   endfunction

endpackage

`default_nettype wire

### design/trimmed_mean_block_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_block_filter
// Windowed mean of signed samples with the window's min and max dropped.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a window fills; nothing comes out until
// the window_len-th request. That request then occupies the block while it
// forms the trimmed sum, runs the restoring divider producing one quotient bit
// per cycle and writes the result register, waiting while the previous result
// has not been taken. Writes to the length register take effect from the next
// request.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_block_filter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [tmbf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [tmbf_pkg::SAMPLE_W-1:0]  rsp_average,
   input  wire logic                                  csr_write_en,
   input  wire logic        [tmbf_pkg::LEN_W-1:0]     csr_write_data
);

   tmbf_pkg::tmbf_cmd_type    cmd;
   tmbf_pkg::tmbf_status_type status;

   tmbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmbf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_average    (rsp_average)
   );

endmodule

`default_nettype wire

### design/tmbf_ctrl.sv
// ----------------------------------------------------------------------------
// tmbf_ctrl
// Sequencer: accepts requests, runs the serial divide and the result write.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbf_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire tmbf_pkg::tmbf_status_type status,
   output tmbf_pkg::tmbf_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_LOAD = 4'b1000
   } tmbf_state_type;

   tmbf_state_type state_ff;
   tmbf_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && status.window_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // hold until the previous result has gone
            if (!status.out_busy) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/tmbf_datapath.sv
// ----------------------------------------------------------------------------
// tmbf_datapath
// Window accumulators, bit-serial restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbf_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire tmbf_pkg::tmbf_cmd_type                  cmd,
   output tmbf_pkg::tmbf_status_type                    status,
   input  wire logic signed [tmbf_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic                                    csr_write_en,
   input  wire logic        [tmbf_pkg::LEN_W-1:0]       csr_write_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed      [tmbf_pkg::SAMPLE_W-1:0]    rsp_average
);

   logic        [tmbf_pkg::LEN_W-1:0]    len_ff, len_in;
   logic        [tmbf_pkg::LEN_W-1:0]    fill_ff, fill_in;
   logic signed [tmbf_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic signed [tmbf_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [tmbf_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic        [tmbf_pkg::LEN_W-1:0]    divisor_ff, divisor_in;
   logic        [tmbf_pkg::LEN_W-1:0]    rem_ff, rem_in;
   logic        [tmbf_pkg::KEPT_W-1:0]   quo_ff, quo_in;
   logic                                 neg_ff, neg_in;
   logic        [tmbf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [tmbf_pkg::SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;

   logic        [tmbf_pkg::LEN_W-1:0]    win_len;
   logic        [tmbf_pkg::LEN_W-1:0]    fill_next;
   logic signed [tmbf_pkg::SUM_W-1:0]    sample_ext;
   logic signed [tmbf_pkg::KEPT_W-1:0]   kept;
   logic        [tmbf_pkg::LEN_W:0]      rem_shift;
   logic        [tmbf_pkg::LEN_W:0]      rem_diff;
   logic        [tmbf_pkg::KEPT_W-1:0]   quo_signed;

   assign win_len    = tmbf_pkg::eff_len(len_ff);
   assign fill_next  = fill_ff + tmbf_pkg::LEN_W'(1);
   assign sample_ext = tmbf_pkg::SUM_W'(req_sample);

   // trimmed sum: drop one min and one max
   assign kept = tmbf_pkg::KEPT_W'(sum_ff) - tmbf_pkg::KEPT_W'(min_ff)
               - tmbf_pkg::KEPT_W'(max_ff);

   assign rem_shift  = {rem_ff, quo_ff[tmbf_pkg::KEPT_W-1]};
   assign rem_diff   = rem_shift - {1'b0, divisor_ff};
   assign quo_signed = neg_ff ? (~quo_ff + tmbf_pkg::KEPT_W'(1)) : quo_ff;

   // a length cut below the current fill closes the window on the next request
   assign status.window_done = (fill_next >= win_len);
   assign status.div_last    = (cnt_ff == '0);
   assign status.out_busy    = rsp_valid_ff && !rsp_ready;

   always_comb begin
      len_in         = len_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      divisor_in     = divisor_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;

      if (csr_write_en) begin
         len_in = csr_write_data;
      end

      if (cmd.take) begin
         if (fill_ff == '0) begin
            sum_in = sample_ext;
            min_in = req_sample;
            max_in = req_sample;
         end else begin
            sum_in = sum_ff + sample_ext;
            if (req_sample < min_ff) begin
               min_in = req_sample;
            end
            if (req_sample > max_ff) begin
               max_in = req_sample;
            end
         end
         if (status.window_done) begin
            fill_in    = '0;
            divisor_in = win_len - tmbf_pkg::LEN_W'(tmbf_pkg::TRIM_COUNT);
         end else begin
            fill_in = fill_next;
         end
      end

      if (cmd.prep) begin
         neg_in = kept[tmbf_pkg::KEPT_W-1];
         quo_in = kept[tmbf_pkg::KEPT_W-1] ? tmbf_pkg::KEPT_W'(-kept)
                                           : tmbf_pkg::KEPT_W'(kept);
         rem_in = '0;
         cnt_in = tmbf_pkg::CNT_W'(tmbf_pkg::KEPT_W - 1);
      end

      if (cmd.step) begin
         if (!rem_diff[tmbf_pkg::LEN_W]) begin
            rem_in = rem_diff[tmbf_pkg::LEN_W-1:0];
            quo_in = {quo_ff[tmbf_pkg::KEPT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[tmbf_pkg::LEN_W-1:0];
            quo_in = {quo_ff[tmbf_pkg::KEPT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - tmbf_pkg::CNT_W'(1);
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = quo_signed[tmbf_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= tmbf_pkg::LEN_W'(tmbf_pkg::LEN_RESET);
         fill_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff         <= min_in;
      max_ff         <= max_in;
      divisor_ff     <= divisor_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      neg_ff         <= neg_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule

`default_nettype wire

### design/tmbf_checker.sv
// ----------------------------------------------------------------------------
// tmbf_checker
// Port-level checks on the trimmed-mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trimmed_mean_block_filter_macros.svh"

module tmbf_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [tmbf_pkg::SAMPLE_W-1:0]    rsp_average
);

   `TMBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average), "result dropped or changed while stalled")

   `TMBF_ASSERT_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready, "block not idle after reset")

   // a result only appears after the block has been busy dividing
   `TMBF_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "result without a divide")

   // the request port does not reopen straight after it closes for a divide
   `TMBF_ASSERT_NEXT(a_busy_span, clock, reset, $fell(req_ready), !req_ready, "divide shorter than expected")

endmodule

bind trimmed_mean_block_filter tmbf_checker u_tmbf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_average    (rsp_average)
);

`default_nettype wire
